/* src/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator: status codes,
// command codes, reset values and the control word that drives the map cells.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Default geometry
  localparam int DEF_NUM_BLOCKS  = 256;
  localparam int DEF_BLOCK_BYTES = 16;

  // Reset value of the base address register
  localparam logic [31:0] BASE_RESET = 32'h2000_1000;

  // Width of the running byte count of a free run: request bytes plus one block
  localparam int RUN_BYTES_W = 17;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_DONE     = 3'd0;
  localparam status_t ST_IGNORED  = 3'd1;
  localparam status_t ST_NO_SPACE = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_ALIGN    = 3'd4;

  // Control word broadcast to every map cell
  typedef struct packed {
    logic shift;  // move the map one cell toward the head
    logic mark;   // set the cells at or above the mark threshold
  } cell_ctl_t;

endpackage

/* src/bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used/free bitmap held in a ring of cells.
// ----------------------------------------------------------------------------
// The used map lives in a ring of NUM_BLOCKS one-bit cells that rotates one
// position per cycle, while a request is served, past a head cell watched by
// the controller. An allocate or free that needs the map makes one full turn
// of the ring, after which the map is back in place, and loads the result
// register at the end of it; a zero-size allocate, a null free and an
// out-of-range free answer at once. A found run is marked in the same turn in
// which it is found, and a free clears the head bit as it wraps to the tail.
// Results wait in an output register; a new word is taken when the ring is
// idle and the output register is empty or is being read. The base address is
// written on the cfg port while idle; the user is bound to this, the block
// itself does not enforce it. After reset every block is free and ready at once.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_base_address,
  // request words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [15:0] in_request_bytes,
  input  logic [31:0] in_release_address,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_granted_address
);

  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int PBW = $clog2(NUM_BLOCKS * BLOCK_BYTES) + 1;
  localparam logic [32:0] HEAP_BYTES = 33'(NUM_BLOCKS * BLOCK_BYTES);

  // Registers
  logic [31:0]          base_r;
  logic                 scan_r,       scan_nxt;
  logic [BW-1:0]        cnt_r,        cnt_nxt;
  logic                 cmd_r;
  logic [15:0]          bytes_r;
  logic [PBW-1:0]       off_r;
  logic [PBW-1:0]       pos_bytes_r,  pos_bytes_nxt;
  logic [BW:0]          run_r,        run_nxt;
  logic [RUN_BYTES_W-1:0] run_bytes_r, run_bytes_nxt;
  logic [PBW-1:0]       start_r,      start_nxt;
  logic                 found_r,      found_nxt;
  logic                 active_r,     active_nxt;
  logic                 matched_r,    matched_nxt;
  logic [31:0]          grant_r,      grant_nxt;
  logic                 out_valid_r,  out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [31:0]          out_addr_r,   out_addr_nxt;

  // Ring wiring and controls
  logic [NUM_BLOCKS-1:0] q;
  logic [NUM_BLOCKS-1:0] d_in;
  cell_ctl_t             ctl;
  logic [BW-1:0]         mark_lo;
  logic                  clr;
  logic                  head;

  // Request decode at accept
  logic        in_fire;
  logic [32:0] heap_top;
  logic        free_null;
  logic        free_range;
  logic [31:0] free_off;

  assign cfg_ready = 1'b1;
  assign in_ready  = !scan_r && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign head      = q[0];

  assign heap_top   = {1'b0, base_r} + HEAP_BYTES;
  assign free_null  = (in_release_address == 32'd0);
  assign free_range = (in_release_address < base_r) ||
                      ({1'b0, in_release_address} >= heap_top);
  assign free_off   = in_release_address - base_r;

  // Base address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_base_address;
    end
  end

  // Controller: one map bit per cycle at the head while a turn is running
  always_comb begin
    logic        hit;
    logic        act;
    logic [RUN_BYTES_W-1:0] rb;
    logic [PBW-1:0] st;

    scan_nxt       = scan_r;
    cnt_nxt        = cnt_r;
    pos_bytes_nxt  = pos_bytes_r;
    run_nxt        = run_r;
    run_bytes_nxt  = run_bytes_r;
    start_nxt      = start_r;
    found_nxt      = found_r;
    active_nxt     = active_r;
    matched_nxt    = matched_r;
    grant_nxt      = grant_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    ctl            = '{shift: 1'b0, mark: 1'b0};
    mark_lo        = '0;
    clr            = 1'b0;
    hit            = 1'b0;
    act            = 1'b0;
    rb             = '0;
    st             = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      // Start a turn, or answer at once
      cnt_nxt       = '0;
      pos_bytes_nxt = '0;
      run_nxt       = '0;
      run_bytes_nxt = '0;
      start_nxt     = '0;
      found_nxt     = 1'b0;
      active_nxt    = 1'b0;
      matched_nxt   = 1'b0;
      grant_nxt     = '0;
      if (in_command == CMD_ALLOC) begin
        if (in_request_bytes == 16'd0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_IGNORED;
          out_addr_nxt   = '0;
        end else begin
          scan_nxt = 1'b1;
        end
      end else begin
        if (free_null) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_IGNORED;
          out_addr_nxt   = '0;
        end else if (free_range) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_RANGE;
          out_addr_nxt   = '0;
        end else begin
          scan_nxt = 1'b1;
        end
      end
    end else if (scan_r) begin
      ctl.shift     = 1'b1;
      pos_bytes_nxt = pos_bytes_r + PBW'(BLOCK_BYTES);
      cnt_nxt       = cnt_r + 1'b1;

      if (cmd_r == CMD_ALLOC) begin
        // First-fit run search
        if (!found_r) begin
          if (head) begin
            run_nxt = '0;
          end else begin
            rb = (run_r == '0) ? RUN_BYTES_W'(BLOCK_BYTES)
                               : run_bytes_r + RUN_BYTES_W'(BLOCK_BYTES);
            st = (run_r == '0) ? pos_bytes_r : start_r;
            run_nxt       = run_r + 1'b1;
            run_bytes_nxt = rb;
            start_nxt     = st;
            if (rb >= RUN_BYTES_W'(bytes_r)) begin
              found_nxt = 1'b1;
              ctl.mark  = 1'b1;
              mark_lo   = BW'((BW+1)'(NUM_BLOCKS) - run_nxt);
              grant_nxt = base_r + 32'(st);
            end
          end
        end
      end else begin
        // Clear used blocks from the addressed block up to the first free one
        hit         = (pos_bytes_r == off_r);
        act         = active_r || hit;
        clr         = act && head;
        active_nxt  = act && head;
        matched_nxt = matched_r || hit;
      end

      // End of the turn: load the result
      if (cnt_r == BW'(NUM_BLOCKS - 1)) begin
        scan_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        if (cmd_r == CMD_ALLOC) begin
          out_status_nxt = found_nxt ? ST_DONE : ST_NO_SPACE;
          out_addr_nxt   = found_nxt ? grant_nxt : 32'd0;
        end else begin
          out_status_nxt = matched_nxt ? ST_DONE : ST_ALIGN;
          out_addr_nxt   = '0;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_command;
      bytes_r <= in_request_bytes;
      off_r   <= PBW'(free_off);
    end
    cnt_r        <= cnt_nxt;
    pos_bytes_r  <= pos_bytes_nxt;
    run_r        <= run_nxt;
    run_bytes_r  <= run_bytes_nxt;
    start_r      <= start_nxt;
    found_r      <= found_nxt;
    active_r     <= active_nxt;
    matched_r    <= matched_nxt;
    grant_r      <= grant_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  // Ring of map cells: each takes its upper neighbor, the tail takes the head
  always_comb begin
    d_in                 = {1'b0, q[NUM_BLOCKS-1:1]};
    d_in[NUM_BLOCKS-1]   = q[0] & ~clr;
  end

  for (genvar p = 0; p < NUM_BLOCKS; p++) begin : g_cell
    bba_cell #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .POS        (p)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .mark_lo (mark_lo),
      .d_in    (d_in[p]),
      .q       (q[p])
    );
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;

endmodule

/* src/bba_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_cell
// One map cell: holds the used bit of one block slot of the rotating map and
// hands it to its neighbor on every shift. A mark sets the cell when its
// position is at or above the threshold, which tags a just-found run.
// ----------------------------------------------------------------------------
module bba_cell
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int POS        = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_ctl_t                     ctl,
  input  logic [$clog2(NUM_BLOCKS)-1:0] mark_lo,
  input  logic                          d_in,
  output logic                          q
);

  localparam int BW = $clog2(NUM_BLOCKS);

  logic q_r;
  logic q_nxt;

  // Next bit: neighbor's bit, forced used when inside the marked run
  always_comb begin
    q_nxt = q_r;
    if (ctl.shift) begin
      q_nxt = d_in | (ctl.mark && (BW'(POS) >= mark_lo));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* tb/tb_bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator
// Self-checking bench for the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
// Drives allocate and free request words through the in_ channel and keeps
// its own copy of the used map and the base address register. Each accepted
// request is predicted at its handshake edge, and every result word is checked
// against the oldest prediction. Directed words cover the field extremes and
// every status, including neighbor release on free, address wrap and a zero
// base. Random traffic follows, mostly allocate/free pairs on live runs with
// some malformed frees, under several sender idle and receiver stall mixes
// and several base addresses.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int MAP_BLOCKS     = DEF_NUM_BLOCKS;
  localparam int BLK_BYTES      = DEF_BLOCK_BYTES;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_WORDS    = 330;

  typedef struct {
    status_t     status;
    logic [31:0] addr;
  } grant_t;

  logic        clk                 = 1'b0;
  logic        rst_n               = 1'b0;
  logic        cfg_valid           = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_base_address    = '0;
  logic        in_valid            = 1'b0;
  logic        in_ready;
  logic        in_command          = CMD_ALLOC;
  logic [15:0] in_request_bytes    = '0;
  logic [31:0] in_release_address  = '0;
  logic        out_valid;
  logic        out_ready           = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_granted_address;

  // Shadow state of the allocator
  logic [31:0] heap_base = BASE_RESET;
  bit          block_used [MAP_BLOCKS];

  grant_t      expected_grants [$];
  int          live_runs [$];       // start blocks of runs handed out
  int          fail_count     = 0;
  int          idle_cycles    = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;

  bitmap_block_allocator #(
    .NUM_BLOCKS (MAP_BLOCKS),
    .BLOCK_BYTES(BLK_BYTES)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_base_address   (cfg_base_address),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_request_bytes   (in_request_bytes),
    .in_release_address (in_release_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_granted_address(out_granted_address)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicts one request and applies it to the shadow map
  function automatic grant_t predict_grant(logic cmd, logic [15:0] bytes,
                                           logic [31:0] addr);
    grant_t      g;
    int          need;
    int          run;
    int          start;
    int          idx;
    int          j;
    bit          found;
    logic [32:0] top;
    logic [31:0] offset;
    g.status = ST_DONE;
    g.addr   = '0;
    if (cmd == CMD_ALLOC) begin
      if (bytes == 16'd0) begin
        g.status = ST_IGNORED;
      end else begin
        need     = (int'(bytes) + BLK_BYTES - 1) / BLK_BYTES;
        g.status = ST_NO_SPACE;
        run      = 0;
        start    = 0;
        found    = 1'b0;
        if (need <= MAP_BLOCKS) begin
          // first-fit scan from block 0
          for (idx = 0; idx < MAP_BLOCKS && !found; idx++) begin
            if (block_used[idx]) begin
              run = 0;
            end else begin
              if (run == 0) start = idx;
              run++;
              if (run == need) found = 1'b1;
            end
          end
        end
        if (found) begin
          for (j = start; j < start + need; j++) block_used[j] = 1'b1;
          g.status = ST_DONE;
          g.addr   = heap_base + 32'(start * BLK_BYTES);
        end
      end
    end else begin
      top = {1'b0, heap_base} + 33'(MAP_BLOCKS * BLK_BYTES);
      if (addr == 32'd0) begin
        g.status = ST_IGNORED;
      end else if (addr < heap_base || {1'b0, addr} >= top) begin
        g.status = ST_RANGE;
      end else begin
        offset = addr - heap_base;
        if (offset % BLK_BYTES != 0) begin
          g.status = ST_ALIGN;
        end else begin
          // clear up to the first free block, may take a neighbor along
          for (idx = int'(offset / BLK_BYTES);
               idx < MAP_BLOCKS && block_used[idx]; idx++)
            block_used[idx] = 1'b0;
        end
      end
    end
    return g;
  endfunction

  // Result check first, then prediction of the word accepted at this edge
  always @(posedge clk) begin
    grant_t g;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result word: status %0d addr %h",
                     out_status, out_granted_address);
        end else begin
          g = expected_grants.pop_front();
          if (out_status !== g.status || out_granted_address !== g.addr) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("mismatch: expected status %0d addr %h, got status %0d addr %h",
                       g.status, g.addr, out_status, out_granted_address);
          end
        end
      end
      if (in_valid && in_ready) begin
        g = predict_grant(in_command, in_request_bytes, in_release_address);
        expected_grants.push_back(g);
        if (in_command == CMD_ALLOC && g.status == ST_DONE)
          live_runs.push_back(int'((g.addr - heap_base) / BLK_BYTES));
      end
      if (cfg_valid && cfg_ready) heap_base = cfg_base_address;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", expected_grants.size());
      $display("bitmap_block_allocator verification failed");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Sends one request word; called and returns at a falling edge
  task automatic issue_request(logic cmd, logic [15:0] bytes, logic [31:0] addr);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_request_bytes   <= bytes;
    in_release_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits for every outstanding result
  task automatic wait_heap_quiet();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk);
  endtask

  // Writes the base address register; block must be quiet
  task automatic program_base(logic [31:0] value);
    cfg_valid        <= 1'b1;
    cfg_base_address <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Allocate sizing, first-fit placement and the no-space cases
  task automatic test_alloc_basics();
    issue_request(CMD_ALLOC, 16'd0, 32'hFFFF_FFFF);     // zero size
    issue_request(CMD_ALLOC, 16'd1, '0);                // block 0
    issue_request(CMD_ALLOC, 16'd16, '0);               // block 1
    issue_request(CMD_ALLOC, 16'd17, '0);               // blocks 2..3
    issue_request(CMD_ALLOC, 16'hFFFF, '0);             // larger than heap
    issue_request(CMD_ALLOC, 16'd4097, '0);             // one block too many
    issue_request(CMD_ALLOC, 16'd4096, '0);             // heap size, no room
  endtask

  // Free checks: null, range, alignment, neighbor release, full heap
  task automatic test_free_checks();
    issue_request(CMD_FREE, 16'hFFFF, 32'd0);
    issue_request(CMD_FREE, '0, BASE_RESET - 32'd1);
    issue_request(CMD_FREE, '0, BASE_RESET + 32'd4096);
    issue_request(CMD_FREE, '0, 32'hFFFF_FFFF);
    issue_request(CMD_FREE, '0, BASE_RESET + 32'd4095);
    issue_request(CMD_FREE, '0, BASE_RESET + 32'd16);   // takes blocks 2..3 too
    issue_request(CMD_FREE, '0, BASE_RESET + 32'd32);   // already free
    issue_request(CMD_FREE, '0, BASE_RESET);
    issue_request(CMD_ALLOC, 16'd4096, '0);             // whole heap
    issue_request(CMD_ALLOC, 16'd1, '0);                // full
    issue_request(CMD_FREE, '0, BASE_RESET + 32'd4080); // last block only
    issue_request(CMD_ALLOC, 16'd16, '0);
    issue_request(CMD_FREE, '0, BASE_RESET);            // clears the lot
    wait_heap_quiet();
  endtask

  // Zero base and an all-ones base with address wrap
  task automatic test_base_extremes();
    program_base(32'h0000_0000);
    issue_request(CMD_ALLOC, 16'd16, '0);               // granted 0, done
    issue_request(CMD_FREE, '0, 32'd0);                 // still null
    wait_heap_quiet();
    program_base(32'hFFFF_FFFF);
    issue_request(CMD_ALLOC, 16'd1, '0);                // wraps to 0x0F
    issue_request(CMD_ALLOC, 16'd1, '0);
    issue_request(CMD_FREE, '0, 32'hFFFF_FFFF);         // blocks 0..2
    issue_request(CMD_FREE, '0, 32'h0000_000F);         // below base
    wait_heap_quiet();
  endtask

  // Random traffic, mostly allocate/free of live runs
  task automatic test_random_traffic(int words, int idle_pct, int stall_pct,
                                     logic [31:0] base);
    int          pick;
    int          slot;
    logic        cmd;
    logic [15:0] bytes;
    logic [31:0] addr;
    program_base(base);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (words) begin
      pick  = $urandom_range(0, 99);
      cmd   = CMD_ALLOC;
      bytes = 16'($urandom);
      addr  = $urandom;
      if (pick < 50) begin
        bytes = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 4096))
                                            : 16'($urandom_range(1, 256));
      end else if (pick < 85) begin
        if (live_runs.size() != 0) begin
          slot = $urandom_range(0, live_runs.size() - 1);
          cmd  = CMD_FREE;
          addr = heap_base + 32'(live_runs[slot] * BLK_BYTES);
          live_runs.delete(slot);
        end else begin
          bytes = 16'($urandom_range(1, 128));
        end
      end else if (pick < 89) begin
        // full-width size, mostly no space
      end else if (pick < 91) begin
        bytes = '0;
      end else if (pick < 93) begin
        cmd  = CMD_FREE;
        addr = '0;
      end else if (pick < 96) begin
        cmd = CMD_FREE;                                 // arbitrary address
      end else if (pick < 98) begin
        cmd  = CMD_FREE;
        addr = heap_base + 32'($urandom_range(0, 255) * BLK_BYTES
                               + $urandom_range(1, BLK_BYTES - 1));
      end else begin
        cmd  = CMD_FREE;
        addr = heap_base + 32'($urandom_range(0, MAP_BLOCKS - 1) * BLK_BYTES);
      end
      issue_request(cmd, bytes, addr);
    end
    wait_heap_quiet();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_alloc_basics();
    test_free_checks();
    test_base_extremes();
    test_random_traffic(PHASE_WORDS, 0, 0, BASE_RESET);
    test_random_traffic(PHASE_WORDS, 54, 0, $urandom);
    test_random_traffic(PHASE_WORDS, 0, 54, 32'hFFFF_F800);
    test_random_traffic(PHASE_WORDS, 30, 30, $urandom);
    // let any stray result show up
    repeat (MAP_BLOCKS + 20) @(negedge clk);
    if (fail_count == 0 && expected_grants.size() == 0) begin
      $display("bitmap_block_allocator verification clean");
    end else begin
      $display("bitmap_block_allocator verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/bba_pkg.sv
src/bba_cell.sv
src/bitmap_block_allocator.sv
tb/tb_bitmap_block_allocator.sv
